// File: rtl/core/hq_pkg.sv
// Shared constants, types and address helpers of the indexed min-heap priority queue.
package hq_pkg;

    // Sizing of the queue
    localparam int CAPACITY    = 64;
    localparam int KEY_COUNT   = 64;
    localparam int WEIGHT_BITS = 16;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Heap nodes are numbered from 1; node n lives in row n/2, half n%2.
    localparam int NODE_W    = $clog2(CAPACITY + 1);
    localparam int ROW_W     = $clog2(CAPACITY / 2 + 1);
    localparam int LEVELS    = $clog2(CAPACITY + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int CELL_AW   = (LEVELS > 2) ? LEVELS - 2 : 1;
    localparam int CELL_ROWS = 2 ** CELL_AW;
    localparam int KIDX_W    = $clog2(KEY_COUNT);

    // Stream word widths
    localparam int IN_W        = MODE_W + KEY_W + WEIGHT_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = STATUS_W + KEY_W + WEIGHT_BITS + 1 + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT,
        MODE_EXTRACT,
        MODE_CHANGE,
        MODE_QUERY
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_EMPTY,
        STAT_FULL,
        STAT_ABSENT,
        STAT_DUPLICATE
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXT_ROOT,
        ST_EXT_LAST,
        ST_POS,
        ST_CHG,
        ST_QRY,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_WR_HOLE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]              key;
        logic signed [WEIGHT_BITS-1:0] weight;
    } entry_t;

    // Two sibling nodes share one row: even node 2r and odd node 2r+1.
    typedef struct packed {
        entry_t odd;
        entry_t even;
    } pair_t;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
        logic               half;
        entry_t             entry;
    } cell_wr_t;

    function automatic logic [ROW_W-1:0] node_row(input logic [NODE_W-1:0] node);
        return ROW_W'(node >> 1);
    endfunction

    // Heap level of a row: row 0 holds the root, row r holds level floor(log2 r)+1.
    function automatic logic [LVL_W-1:0] row_level(input logic [ROW_W-1:0] row);
        logic [LVL_W-1:0] lv;
        lv = '0;
        for (int b = 0; b < ROW_W; b++) begin
            if (row[b]) begin
                lv = LVL_W'(b + 1);
            end
        end
        return lv;
    endfunction

    // Row address inside its level cell: drop the leading one.
    function automatic logic [CELL_AW-1:0] row_local(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] lead;
        lead = '0;
        for (int b = 0; b < ROW_W; b++) begin
            if (row[b]) begin
                lead = ROW_W'(1) << b;
            end
        end
        return CELL_AW'(row & ~lead);
    endfunction

    function automatic entry_t pick_half(input pair_t pair, input logic half);
        return half ? pair.odd : pair.even;
    endfunction

endpackage

// File: rtl/core/indexed_min_heap_priority_queue.sv
// Top level of the indexed min-heap priority queue: sequencer, key tables and level cells.
//
//  channel | dir | handshake         | word contents (lowest bit first)
//  --------+-----+-------------------+---------------------------------------------------
//  s_      | in  | s_tvalid/s_tready | mode[1:0], key[7:2], weight[23:8]
//  m_      | out | m_tvalid/m_tready | status[2:0], out_key[8:3], out_weight[24:9],
//          |     |                   | present[25], count[32:26], zero[39:33]
//
// One word at a time. Errors go straight to the response state. Insert lets the new entry rise
// level by level; extract moves the last entry to the root and lets it sink, unless that empties
// the queue. Change lets the entry rise when the weight drops and sink otherwise. Each level
// step is a registered row read from one level cell, then compare-and-move. Reset (aresetn low,
// synchronous) empties the queue and clears every presence bit. A new word is taken while the
// previous result still waits on m_tready; that result must leave before the new one is posted,
// so stalls hold the sequencer in its response state.
module indexed_min_heap_priority_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode, key, weight
    input  logic [hq_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, out_key, out_weight, present, count
    output logic [hq_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hq_pkg::*;

    // Control state
    state_t                  state_reg, state_next;
    logic [NODE_W-1:0]       cnt_reg, cnt_next;
    logic [KEY_COUNT-1:0]    present_reg, present_next;
    logic                    m_valid_reg, m_valid_next;

    // Payload registers
    logic [OUT_TDATA_W-1:0]  m_data_reg, m_data_next;
    status_t                 res_status_reg, res_status_next;
    logic [KEY_W-1:0]        res_key_reg, res_key_next;
    logic [WEIGHT_BITS-1:0]  res_w_reg, res_w_next;
    logic                    res_pres_reg, res_pres_next;
    mode_t                   mode_reg, mode_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [WEIGHT_BITS-1:0]  w_reg, w_next;
    logic [NODE_W-1:0]       n_reg, n_next;
    entry_t                  hole_reg, hole_next;
    logic [LVL_W-1:0]        rd_lvl_reg;

    // Key to node table
    logic [NODE_W-1:0]       pos_mem [KEY_COUNT];
    logic [NODE_W-1:0]       pos_rd_reg;
    logic                    pos_we;
    logic [KIDX_W-1:0]       pos_waddr;
    logic [NODE_W-1:0]       pos_wdata;

    // Input word fields
    mode_t                   in_mode;
    logic [KEY_W-1:0]        in_key;
    logic [WEIGHT_BITS-1:0]  in_w;
    logic [KIDX_W-1:0]       in_kidx;
    logic                    in_fire;
    logic                    in_kvalid;
    logic                    in_present;
    logic                    full;

    // Level cell ports
    logic [ROW_W-1:0]        rd_row;
    logic [LVL_W-1:0]        rd_lvl;
    logic [CELL_AW-1:0]      rd_local;
    pair_t                   cell_rd [LEVELS];
    cell_wr_t                cell_wr [LEVELS];
    pair_t                   rd_pair;
    logic                    wr_en;
    logic [NODE_W-1:0]       wr_node;
    entry_t                  wr_entry;
    logic [ROW_W-1:0]        wr_row;
    logic [LVL_W-1:0]        wr_lvl;

    // Sift decisions
    logic [NODE_W-1:0]       par_node;
    entry_t                  par;
    entry_t                  node_entry;
    logic [NODE_W:0]         kid_l, kid_r, cnt_ext;
    logic                    take_r;
    entry_t                  kid;
    logic [NODE_W-1:0]       kid_node;
    logic                    up_move, dn_move, chg_up, resp_go;

    assign in_mode    = mode_t'(s_tdata[MODE_W-1:0]);
    assign in_key     = s_tdata[MODE_W +: KEY_W];
    assign in_w       = s_tdata[MODE_W + KEY_W +: WEIGHT_BITS];
    assign in_kidx    = KIDX_W'(in_key);
    assign in_fire    = s_tvalid && s_tready;
    assign in_kvalid  = int'(in_key) < KEY_COUNT;
    assign in_present = in_kvalid && present_reg[in_kidx];
    assign full       = cnt_reg == NODE_W'(CAPACITY);

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign rd_pair    = cell_rd[rd_lvl_reg];
    assign rd_lvl     = row_level(rd_row);
    assign rd_local   = row_local(rd_row);
    assign wr_row     = node_row(wr_node);
    assign wr_lvl     = row_level(wr_row);

    // Parent step: the hole at node n against its parent n/2.
    assign par_node   = n_reg >> 1;
    assign par        = pick_half(rd_pair, par_node[0]);
    assign up_move    = $signed(par.weight) > $signed(hole_reg.weight);

    // Child step: right child wins only when strictly lighter than the left one.
    assign kid_l      = {n_reg, 1'b0};
    assign kid_r      = {n_reg, 1'b1};
    assign cnt_ext    = {1'b0, cnt_reg};
    assign take_r     = (kid_r <= cnt_ext)
                        && ($signed(rd_pair.odd.weight) < $signed(rd_pair.even.weight));
    assign kid        = take_r ? rd_pair.odd : rd_pair.even;
    assign kid_node   = NODE_W'(take_r ? kid_r : kid_l);
    assign dn_move    = $signed(kid.weight) < $signed(hole_reg.weight);

    assign node_entry = pick_half(rd_pair, n_reg[0]);
    assign chg_up     = $signed(w_reg) < $signed(node_entry.weight);
    assign resp_go    = !m_valid_reg || m_tready;

    // One cell per heap level; the walk moves one cell per step.
    genvar gi;
    generate
        for (gi = 0; gi < LEVELS; gi++) begin : g_level
            always_comb begin
                cell_wr[gi].en    = wr_en && (wr_lvl == LVL_W'(gi));
                cell_wr[gi].addr  = row_local(wr_row);
                cell_wr[gi].half  = wr_node[0];
                cell_wr[gi].entry = wr_entry;
            end

            hq_cell u_cell (
                .aclk    (aclk),
                .rd_addr (rd_local),
                .wr      (cell_wr[gi]),
                .rd_pair (cell_rd[gi])
            );
        end
    endgenerate

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (in_mode) inside
                        MODE_INSERT: begin
                            state_next = (!in_kvalid || in_present || full) ? ST_RESP
                                                                            : ST_UP_RD;
                        end
                        MODE_EXTRACT: begin
                            state_next = (cnt_reg == '0) ? ST_RESP : ST_EXT_ROOT;
                        end
                        MODE_CHANGE, MODE_QUERY: begin
                            state_next = in_present ? ST_POS : ST_RESP;
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_EXT_ROOT: state_next = (cnt_reg == NODE_W'(1)) ? ST_RESP : ST_EXT_LAST;
            ST_EXT_LAST: state_next = ST_DN_RD;
            ST_POS:      state_next = (mode_reg == MODE_CHANGE) ? ST_CHG : ST_QRY;
            ST_CHG:      state_next = chg_up ? ST_UP_RD : ST_DN_RD;
            ST_QRY:      state_next = ST_RESP;
            ST_UP_RD:    state_next = (n_reg == NODE_W'(1)) ? ST_WR_HOLE : ST_UP_CMP;
            ST_UP_CMP:   state_next = up_move ? ST_UP_RD : ST_WR_HOLE;
            ST_DN_RD:    state_next = (kid_l > cnt_ext) ? ST_WR_HOLE : ST_DN_CMP;
            ST_DN_CMP:   state_next = dn_move ? ST_DN_RD : ST_WR_HOLE;
            ST_WR_HOLE:  state_next = ST_RESP;
            ST_RESP:     state_next = resp_go ? ST_IDLE : ST_RESP;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        cnt_next        = cnt_reg;
        present_next    = present_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_w_next      = res_w_reg;
        res_pres_next   = res_pres_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        w_next          = w_reg;
        n_next          = n_reg;
        hole_next       = hole_reg;
        rd_row          = '0;
        wr_en           = 1'b0;
        wr_node         = n_reg;
        wr_entry        = hole_reg;
        pos_we          = 1'b0;
        pos_waddr       = KIDX_W'(hole_reg.key);
        pos_wdata       = n_reg;

        // drop the posted result once it is taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    mode_next       = in_mode;
                    key_next        = in_key;
                    w_next          = in_w;
                    res_key_next    = in_key;
                    res_w_next      = '0;
                    res_pres_next   = 1'b0;
                    res_status_next = STAT_OK;
                    unique case (in_mode) inside
                        MODE_INSERT: begin
                            if (!in_kvalid) begin
                                res_status_next = STAT_ABSENT;
                            end else if (in_present) begin
                                res_status_next = STAT_DUPLICATE;
                            end else if (full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                // new entry enters as the hole at the next free node
                                cnt_next              = cnt_reg + NODE_W'(1);
                                n_next                = cnt_reg + NODE_W'(1);
                                present_next[in_kidx] = 1'b1;
                                hole_next.key         = in_key;
                                hole_next.weight      = in_w;
                            end
                        end
                        MODE_EXTRACT: begin
                            if (cnt_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end
                            rd_row = '0;
                        end
                        MODE_CHANGE, MODE_QUERY: begin
                            if (!in_present) begin
                                res_status_next = STAT_ABSENT;
                            end
                        end
                        default: res_status_next = STAT_ABSENT;
                    endcase
                end
            end
            ST_EXT_ROOT: begin
                res_key_next = rd_pair.odd.key;
                res_w_next   = rd_pair.odd.weight;
                present_next[KIDX_W'(rd_pair.odd.key)] = 1'b0;
                cnt_next     = cnt_reg - NODE_W'(1);
                n_next       = cnt_reg;
                rd_row       = node_row(cnt_reg);
            end
            ST_EXT_LAST: begin
                // last entry becomes the hole at the root
                hole_next = node_entry;
                n_next    = NODE_W'(1);
            end
            ST_POS: begin
                n_next = pos_rd_reg;
                rd_row = node_row(pos_rd_reg);
            end
            ST_CHG: begin
                hole_next.key    = key_reg;
                hole_next.weight = w_reg;
            end
            ST_QRY: begin
                res_w_next    = node_entry.weight;
                res_pres_next = 1'b1;
            end
            ST_UP_RD: begin
                rd_row = node_row(par_node);
            end
            ST_UP_CMP: begin
                if (up_move) begin
                    // parent moves down into the hole
                    wr_en     = 1'b1;
                    wr_entry  = par;
                    pos_we    = 1'b1;
                    pos_waddr = KIDX_W'(par.key);
                    n_next    = par_node;
                end
            end
            ST_DN_RD: begin
                rd_row = ROW_W'(n_reg);
            end
            ST_DN_CMP: begin
                if (dn_move) begin
                    // lighter child moves up into the hole
                    wr_en     = 1'b1;
                    wr_entry  = kid;
                    pos_we    = 1'b1;
                    pos_waddr = KIDX_W'(kid.key);
                    n_next    = kid_node;
                end
            end
            ST_WR_HOLE: begin
                wr_en  = 1'b1;
                pos_we = 1'b1;
            end
            ST_RESP: begin
                if (resp_go) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({COUNT_W'(cnt_reg), res_pres_reg, res_w_reg,
                                                 res_key_reg, res_status_reg});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            present_reg <= present_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg     <= m_data_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_w_reg      <= res_w_next;
        res_pres_reg   <= res_pres_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        w_reg          <= w_next;
        n_reg          <= n_next;
        hole_reg       <= hole_next;
        rd_lvl_reg     <= rd_lvl;
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd_reg <= pos_mem[in_kidx];
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NODE_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && cnt_reg != $past(cnt_reg)) |->
        (cnt_reg == $past(cnt_reg) + NODE_W'(1) || cnt_reg == $past(cnt_reg) - NODE_W'(1)))
        else $error("entry count moved by more than one");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_RESP))
        else $error("result posted outside the response state");

    a_walk_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UP_RD || state_reg == ST_UP_CMP || state_reg == ST_DN_RD
         || state_reg == ST_DN_CMP || state_reg == ST_WR_HOLE)
        |-> (n_reg != '0 && n_reg <= cnt_reg))
        else $error("sift walk left the occupied heap");
`endif

endmodule

// File: rtl/core/hq_cell.sv
// One heap level cell: sibling-pair storage with one write and one registered read.
module hq_cell (
    input  logic                       aclk,
    input  logic [hq_pkg::CELL_AW-1:0] rd_addr,
    input  hq_pkg::cell_wr_t           wr,
    output hq_pkg::pair_t              rd_pair
);
    import hq_pkg::*;

    entry_t mem_even [CELL_ROWS];
    entry_t mem_odd  [CELL_ROWS];
    pair_t  rd_pair_reg;

    always_ff @(posedge aclk) begin
        if (wr.en && !wr.half) begin
            mem_even[wr.addr] <= wr.entry;
        end
        if (wr.en && wr.half) begin
            mem_odd[wr.addr] <= wr.entry;
        end
        rd_pair_reg.even <= mem_even[rd_addr];
        rd_pair_reg.odd  <= mem_odd[rd_addr];
    end

    assign rd_pair = rd_pair_reg;

endmodule
